// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the relocation patcher.
// Depends on nothing; users supply clk and rst_n in their scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define MHLRP_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MHLRP_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mhlrp_pkg.sv =====
// Types and constants of the HI16/LO16 relocation patcher.
// No dependencies; imported by every RTL module of the block.
package mhlrp_pkg;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned SIZE_W    = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RODATA_SIZE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE   = 4'd3;

    // symbol section codes, reloc_word[31:28]
    localparam logic [3:0] SYM_TEXT   = 4'd0;
    localparam logic [3:0] SYM_RODATA = 4'd1;
    localparam logic [3:0] SYM_DATA   = 4'd2;
    localparam logic [3:0] SYM_BSS    = 4'd3;

    // target section codes, reloc_word[27:26]
    localparam logic [1:0] TGT_TEXT   = 2'd0;
    localparam logic [1:0] TGT_DATA   = 2'd1;
    localparam logic [1:0] TGT_RODATA = 2'd2;

    // relocation types, reloc_word[25:22]
    localparam logic [3:0] RT_HI16  = 4'd0;
    localparam logic [3:0] RT_LO16  = 4'd1;
    localparam logic [3:0] RT_R26   = 4'd2;
    localparam logic [3:0] RT_WORD5 = 4'd5;
    localparam logic [3:0] RT_WORD6 = 4'd6;

    localparam logic [31:0] R26_MASK = 32'h0FFF_FFFF;

    typedef struct packed {
        logic [31:0] text;
        logic [31:0] rodata;
        logic [31:0] data;
        logic [31:0] bss;
    } bases_t;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic        half_write;
        logic        last_patch;
    } result_t;

endpackage

// ===== rtl/mips_hi_lo_relocation_patcher_top.sv =====
// MIPS HI16/LO16 relocation patcher, top level.
// A request is taken into the input register, then loaded into the output slots once they are free.
// Throughput: one request per cycle, set by the input register and output slots, while the slots can drain;
// a LO16 with a pending HI16 gives two patches and holds the output until both are taken.
// Reset (rst_n, async low) clears config, section bases, HI16 history, all valids.
module mips_hi_lo_relocation_patcher_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mhlrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [31:0]                          reloc_word,
    input  logic [31:0]                          target_word,
    input  logic                                 last_reloc,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [31:0]                          write_address,
    output logic [31:0]                          write_data,
    output logic                                 half_write,
    output logic                                 last_patch
);
    import mhlrp_pkg::*;

    `include "assert_macros.svh"

    bases_t      bases;
    logic        s1_valid_reg;
    logic [31:0] s1_reloc_reg;
    logic [31:0] s1_word_reg;
    logic        s1_last_reg;
    logic        s1_fire;
    logic        res0_valid, res1_valid;
    result_t     res0, res1, out_res;
    logic        out_free, both_valid, first_valid, hi_pending;

    mhlrp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bases     (bases)
    );

    assign s1_fire  = s1_valid_reg & out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reloc_reg <= reloc_word;
            s1_word_reg  <= target_word;
            s1_last_reg  <= last_reloc;
        end
    end

    mhlrp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .bases       (bases),
        .fire        (s1_fire),
        .reloc_word  (s1_reloc_reg),
        .target_word (s1_word_reg),
        .last_reloc  (s1_last_reg),
        .res0_valid  (res0_valid),
        .res0        (res0),
        .res1_valid  (res1_valid),
        .res1        (res1),
        .hi_pending  (hi_pending)
    );

    mhlrp_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_fire),
        .res0_valid  (res0_valid),
        .res0        (res0),
        .res1_valid  (res1_valid),
        .res1        (res1),
        .free        (out_free),
        .both_valid  (both_valid),
        .first_valid (first_valid),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (out_res)
    );

    assign write_address = out_res.write_address;
    assign write_data    = out_res.write_data;
    assign half_write    = out_res.half_write;
    assign last_patch    = out_res.last_patch;

    // the upper-word patch never stands without its halfword behind it
    `MHLRP_CHECK_ALWAYS(a_first_has_second, first_valid |-> (out_valid && !last_patch), "upper-word patch without trailing halfword")
    // two patches in the slots always come from a LO16: second is a halfword
    `MHLRP_CHECK(a_pair_is_lo16, both_valid |=> (out_valid && (half_write || !last_patch)), "patch pair not from LO16")
    // a new request never overwrites a full pair
    `MHLRP_CHECK(a_no_overwrite, s1_fire |-> !both_valid, "request loaded over pending patches")
    // a HI16 not marked last leaves a pending upper word
    `MHLRP_CHECK(a_hi16_pending, (s1_fire && s1_reloc_reg[25:22] == RT_HI16 && !s1_last_reg) |=> hi_pending, "HI16 not recorded")

endmodule

// ===== rtl/mhlrp_cfg.sv =====
// Configuration registers and precomputed section base addresses.
// Depends on mhlrp_pkg.
module mhlrp_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mhlrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                          cfg_data,
    output mhlrp_pkg::bases_t                    bases
);
    import mhlrp_pkg::*;

    logic [31:0]       load_base_reg, load_base_next;
    logic [SIZE_W-1:0] text_size_reg, text_size_next;
    logic [SIZE_W-1:0] rodata_size_reg, rodata_size_next;
    logic [SIZE_W-1:0] data_size_reg, data_size_next;
    bases_t            bases_reg, bases_next;

    always_comb
    begin
        load_base_next   = load_base_reg;
        text_size_next   = text_size_reg;
        rodata_size_next = rodata_size_reg;
        data_size_next   = data_size_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOAD_BASE:   load_base_next   = cfg_data;
                CFG_TEXT_SIZE:   text_size_next   = cfg_data[SIZE_W-1:0];
                CFG_RODATA_SIZE: rodata_size_next = cfg_data[SIZE_W-1:0];
                CFG_DATA_SIZE:   data_size_next   = cfg_data[SIZE_W-1:0];
                default:         ;
            endcase
        end
        // bases follow the new register values in the same edge
        bases_next.text   = load_base_next;
        bases_next.rodata = load_base_next + {8'h00, text_size_next};
        bases_next.data   = bases_next.rodata + {8'h00, rodata_size_next};
        bases_next.bss    = bases_next.data + {8'h00, data_size_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg   <= '0;
            text_size_reg   <= '0;
            rodata_size_reg <= '0;
            data_size_reg   <= '0;
            bases_reg       <= '0;
        end
        else
        begin
            load_base_reg   <= load_base_next;
            text_size_reg   <= text_size_next;
            rodata_size_reg <= rodata_size_next;
            data_size_reg   <= data_size_next;
            bases_reg       <= bases_next;
        end
    end

    assign bases = bases_reg;

endmodule

// ===== rtl/mhlrp_core.sv =====
// Relocation decode, patch arithmetic and HI16/section-base history.
// Depends on mhlrp_pkg.
module mhlrp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  mhlrp_pkg::bases_t   bases,
    input  logic                fire,
    input  logic [31:0]         reloc_word,
    input  logic [31:0]         target_word,
    input  logic                last_reloc,
    output logic                res0_valid,
    output mhlrp_pkg::result_t  res0,
    output logic                res1_valid,
    output mhlrp_pkg::result_t  res1,
    output logic                hi_pending
);
    import mhlrp_pkg::*;

    logic        hi_pending_reg, hi_pending_next;
    logic [31:0] hi_address_reg, hi_address_next;
    logic [31:0] hi_word_reg, hi_word_next;
    logic [31:0] prev_sym_reg, prev_sym_next;
    logic [31:0] prev_tgt_reg, prev_tgt_next;

    logic [3:0]  sym_sec;
    logic [1:0]  tgt_sec;
    logic [3:0]  rtype;
    logic [31:0] offset;
    logic [31:0] sym_base;
    logic [31:0] tgt_base;
    logic [31:0] addr;
    logic [15:0] lo;
    logic [31:0] imm_raw;
    logic [15:0] imm_hi;

    assign sym_sec = reloc_word[31:28];
    assign tgt_sec = reloc_word[27:26];
    assign rtype   = reloc_word[25:22];
    assign offset  = {9'd0, reloc_word[21:0], 1'b0};

    always_comb
    begin
        unique case (sym_sec)
            SYM_TEXT:   sym_base = bases.text;
            SYM_RODATA: sym_base = bases.rodata;
            SYM_DATA:   sym_base = bases.data;
            SYM_BSS:    sym_base = bases.bss;
            default:    sym_base = prev_sym_reg;
        endcase
        unique case (tgt_sec)
            TGT_TEXT:   tgt_base = bases.text;
            TGT_DATA:   tgt_base = bases.data;
            TGT_RODATA: tgt_base = bases.rodata;
            default:    tgt_base = prev_tgt_reg;
        endcase
    end

    assign addr    = tgt_base + offset;
    assign lo      = target_word[15:0];
    assign imm_raw = {hi_word_reg[15:0], 16'h0000} + {16'h0000, lo} + sym_base;
    // carry-in from a negative low half, minus the sign of the LO16 immediate
    assign imm_hi  = imm_raw[31:16] + {15'd0, imm_raw[15]} - {15'd0, lo[15]};

    always_comb
    begin
        res0_valid = 1'b0;
        res1_valid = 1'b0;
        res0.write_address = hi_address_reg;
        res0.write_data    = {hi_word_reg[31:16], imm_hi};
        res0.half_write    = 1'b0;
        res0.last_patch    = 1'b0;
        res1.write_address = addr;
        res1.write_data    = target_word + sym_base;
        res1.half_write    = 1'b0;
        res1.last_patch    = 1'b1;

        hi_pending_next = hi_pending_reg;
        hi_address_next = hi_address_reg;
        hi_word_next    = hi_word_reg;

        unique case (rtype)
            RT_HI16:
            begin
                hi_pending_next = 1'b1;
                hi_address_next = addr;
                hi_word_next    = target_word;
            end
            RT_LO16:
            begin
                res0_valid         = hi_pending_reg;
                res1_valid         = 1'b1;
                res1.write_address = addr + 32'd2;
                res1.write_data    = {16'h0000, imm_raw[15:0]};
                res1.half_write    = 1'b1;
                hi_pending_next    = 1'b0;
            end
            RT_R26:
            begin
                res1_valid      = 1'b1;
                res1.write_data = target_word + {2'b00, sym_base[31:2] & R26_MASK[31:2]};
            end
            RT_WORD5, RT_WORD6:
            begin
                res1_valid = 1'b1;
            end
            default: ;
        endcase

        if (last_reloc)
            hi_pending_next = 1'b0;

        prev_sym_next = sym_base;
        prev_tgt_next = tgt_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_pending_reg <= 1'b0;
            hi_address_reg <= '0;
            hi_word_reg    <= '0;
            prev_sym_reg   <= '0;
            prev_tgt_reg   <= '0;
        end
        else if (fire)
        begin
            hi_pending_reg <= hi_pending_next;
            hi_address_reg <= hi_address_next;
            hi_word_reg    <= hi_word_next;
            prev_sym_reg   <= prev_sym_next;
            prev_tgt_reg   <= prev_tgt_next;
        end
    end

    assign hi_pending = hi_pending_reg;

endmodule

// ===== rtl/mhlrp_out.sv =====
// Two-slot result register: holds the one or two patches of a request.
// Depends on mhlrp_pkg.
module mhlrp_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                res0_valid,
    input  mhlrp_pkg::result_t  res0,
    input  logic                res1_valid,
    input  mhlrp_pkg::result_t  res1,
    output logic                free,
    output logic                both_valid,
    output logic                first_valid,
    output logic                out_valid,
    input  logic                out_ready,
    output mhlrp_pkg::result_t  out_res
);
    import mhlrp_pkg::*;

    logic    p0_valid_reg, p0_valid_next;
    logic    p1_valid_reg, p1_valid_next;
    result_t p0_reg;
    result_t p1_reg;
    logic    pop;

    assign out_valid   = p0_valid_reg | p1_valid_reg;
    assign out_res     = p0_valid_reg ? p0_reg : p1_reg;
    assign pop         = out_valid & out_ready;
    // slots are empty or drain fully in this cycle
    assign free        = !out_valid || (out_ready && !(p0_valid_reg && p1_valid_reg));
    assign both_valid  = p0_valid_reg & p1_valid_reg;
    assign first_valid = p0_valid_reg;

    always_comb
    begin
        p0_valid_next = p0_valid_reg;
        p1_valid_next = p1_valid_reg;
        if (pop)
        begin
            if (p0_valid_reg)
                p0_valid_next = 1'b0;
            else
                p1_valid_next = 1'b0;
        end
        if (load)
        begin
            p0_valid_next = res0_valid;
            p1_valid_next = res1_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p0_valid_reg <= p0_valid_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p0_reg <= res0;
            p1_reg <= res1;
        end
    end

endmodule
